[src/ssnd_pkg.sv]
`timescale 1ns / 1ps

package ssnd_pkg;

  // Display geometry and field widths.
  localparam int DIGIT_COUNT = 4;
  localparam int SEL_W       = $clog2(DIGIT_COUNT);
  localparam int VALUE_W     = 24;
  localparam int SUM_W       = VALUE_W + 1;
  localparam int NUM_W       = 14;
  localparam int PROD_W      = 49;

  // Function codes carried on the selector.
  localparam logic FUNC_NUMBER = 1'b0;
  localparam logic FUNC_DIGIT  = 1'b1;

  // Range boundaries, in thousandths.
  localparam logic [VALUE_W-1:0] LIMIT_OVERFLOW  = 24'd10000000;
  localparam logic [VALUE_W-1:0] LIMIT_THOUSANDS = 24'd1000000;
  localparam logic [VALUE_W-1:0] LIMIT_HUNDREDS  = 24'd100000;
  localparam logic [VALUE_W-1:0] LIMIT_TENS      = 24'd10000;

  // Half of the dropped place, added before truncation for round half up.
  localparam logic [SUM_W-1:0] HALF_THOUSANDS = 25'd500;
  localparam logic [SUM_W-1:0] HALF_HUNDREDS  = 25'd50;
  localparam logic [SUM_W-1:0] HALF_TENS      = 25'd5;

  // Reciprocals that divide exactly for any 24-bit dividend.
  localparam logic [SUM_W-1:0] MAGIC_DIV1000 = 25'd17179870;  // ceil(2^34 / 1000)
  localparam logic [SUM_W-1:0] MAGIC_DIV100  = 25'd21474837;  // ceil(2^31 / 100)
  localparam logic [SUM_W-1:0] MAGIC_DIV10   = 25'd26843546;  // ceil(2^28 / 10)

  localparam logic [NUM_W-1:0] NUM_CARRY = 14'd10000;
  localparam logic [NUM_W-1:0] NUM_MAX   = 14'd9999;
  localparam logic [NUM_W-1:0] NUM_LOW   = 14'd1000;

  localparam logic [7:0] SEG_BLANK = 8'hFF;

  // Which place the decimal point follows; overflow has no point.
  typedef enum logic [2:0] {
    RANGE_UNITS     = 3'd0,
    RANGE_TENS      = 3'd1,
    RANGE_HUNDREDS  = 3'd2,
    RANGE_THOUSANDS = 3'd3,
    RANGE_OVERFLOW  = 3'd4
  } range_t;

  // One classified item as it waits between front and back.
  typedef struct packed {
    logic             func;
    logic [NUM_W-1:0] num;
    range_t           range;
    logic [3:0]       digit_code;
    logic [SEL_W-1:0] digit_pos;
    logic             dot_en;
  } item_t;

  // Segment pattern of a digit, active low, dot off.
  function automatic logic [7:0] seg_pattern(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'hC0;
      4'd1:    s = 8'hF9;
      4'd2:    s = 8'hA4;
      4'd3:    s = 8'hB0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hF8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h90;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

  // Weight of a digit position, leftmost first.
  function automatic logic [NUM_W-1:0] place_weight(input logic [SEL_W-1:0] p);
    logic [NUM_W-1:0] w;
    unique case (p)
      2'd0:    w = 14'd1000;
      2'd1:    w = 14'd100;
      2'd2:    w = 14'd10;
      default: w = 14'd1;
    endcase
    return w;
  endfunction

endpackage

[src/ssnd_front.sv]
`timescale 1ns / 1ps

module ssnd_front import ssnd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic [VALUE_W-1:0] value_milli,
  input  logic [3:0]         digit_code,
  input  logic [SEL_W-1:0]   digit_pos,
  input  logic               dot_en,
  output logic               push_valid,
  input  logic               push_ready,
  output item_t              push_item
);

  // Stage one: range and rounded dividend.
  logic               s1_v_r;
  logic               s1_func_r;
  range_t             s1_range_r;
  logic [SUM_W-1:0]   s1_sum_r;
  logic [3:0]         s1_dv_r;
  logic [SEL_W-1:0]   s1_idx_r;
  logic               s1_dot_r;

  // Stage two: product of the dividend and the reciprocal.
  logic               s2_v_r;
  logic               s2_func_r;
  range_t             s2_range_r;
  logic [PROD_W-1:0]  s2_prod_r;
  logic [NUM_W-1:0]   s2_low_r;
  logic [3:0]         s2_dv_r;
  logic [SEL_W-1:0]   s2_idx_r;
  logic               s2_dot_r;

  range_t             range_nxt;
  logic [SUM_W-1:0]   half_sel;
  logic [SUM_W-1:0]   sum_nxt;
  logic [SUM_W-1:0]   magic_sel;
  logic [PROD_W-1:0]  prod_nxt;
  logic [NUM_W-1:0]   num_raw;
  logic               advance;

  // The whole pipe moves unless its last stage is blocked by a full queue.
  assign advance  = !s2_v_r || push_ready;
  assign in_ready = advance;

  // Classify the magnitude into its display range.
  always_comb begin
    if (value_milli >= LIMIT_OVERFLOW) begin
      range_nxt = RANGE_OVERFLOW;
    end else if (value_milli >= LIMIT_THOUSANDS) begin
      range_nxt = RANGE_THOUSANDS;
    end else if (value_milli >= LIMIT_HUNDREDS) begin
      range_nxt = RANGE_HUNDREDS;
    end else if (value_milli >= LIMIT_TENS) begin
      range_nxt = RANGE_TENS;
    end else begin
      range_nxt = RANGE_UNITS;
    end
  end

  always_comb begin
    unique case (range_nxt)
      RANGE_THOUSANDS: half_sel = HALF_THOUSANDS;
      RANGE_HUNDREDS:  half_sel = HALF_HUNDREDS;
      RANGE_TENS:      half_sel = HALF_TENS;
      default:         half_sel = '0;
    endcase
  end

  assign sum_nxt = SUM_W'(value_milli) + half_sel;

  // Divide by the dropped place as a multiplication by its reciprocal.
  always_comb begin
    unique case (s1_range_r)
      RANGE_THOUSANDS: magic_sel = MAGIC_DIV1000;
      RANGE_HUNDREDS:  magic_sel = MAGIC_DIV100;
      default:         magic_sel = MAGIC_DIV10;
    endcase
  end

  assign prod_nxt = PROD_W'(s1_sum_r[VALUE_W-1:0]) * PROD_W'(magic_sel);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (advance) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_func_r  <= in_func;
      s1_range_r <= range_nxt;
      s1_sum_r   <= sum_nxt;
      s1_dv_r    <= digit_code;
      s1_idx_r   <= digit_pos;
      s1_dot_r   <= dot_en;
      s2_func_r  <= s1_func_r;
      s2_range_r <= s1_range_r;
      s2_prod_r  <= prod_nxt;
      s2_low_r   <= s1_sum_r[NUM_W-1:0];
      s2_dv_r    <= s1_dv_r;
      s2_idx_r   <= s1_idx_r;
      s2_dot_r   <= s1_dot_r;
    end
  end

  // Pick the quotient bits for the range.
  always_comb begin
    unique case (s2_range_r)
      RANGE_THOUSANDS: num_raw = s2_prod_r[47:34];
      RANGE_HUNDREDS:  num_raw = s2_prod_r[44:31];
      RANGE_TENS:      num_raw = s2_prod_r[41:28];
      RANGE_UNITS:     num_raw = s2_low_r;
      default:         num_raw = NUM_MAX;
    endcase
  end

  // A rounding carry to 10000 reads as 1000 in the next coarser range; from thousands it reads as overflow.
  always_comb begin
    push_item.func       = s2_func_r;
    push_item.digit_code = s2_dv_r;
    push_item.digit_pos  = s2_idx_r;
    push_item.dot_en     = s2_dot_r;
    push_item.num        = num_raw;
    push_item.range      = s2_range_r;
    if (num_raw == NUM_CARRY) begin
      unique case (s2_range_r)
        RANGE_TENS: begin
          push_item.num   = NUM_LOW;
          push_item.range = RANGE_HUNDREDS;
        end
        RANGE_HUNDREDS: begin
          push_item.num   = NUM_LOW;
          push_item.range = RANGE_THOUSANDS;
        end
        default: begin
          push_item.num   = NUM_MAX;
          push_item.range = RANGE_OVERFLOW;
        end
      endcase
    end
  end

  assign push_valid = s2_v_r;

endmodule

[src/ssnd_queue.sv]
`timescale 1ns / 1ps

module ssnd_queue import ssnd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop,
  output item_t pop_item
);

  // Two-entry queue between the classifier and the digit sequencer.
  item_t       entry_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;
  logic [1:0]  count_nxt;
  logic        do_push;
  logic        do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_item   = entry_r[rd_ptr_r];

  assign do_push = push_valid && push_ready;
  assign do_pop  = pop && pop_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[src/ssnd_back.sv]
`timescale 1ns / 1ps

module ssnd_back import ssnd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  item_t            head_item,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       segment_byte,
  output logic [SEL_W-1:0] digit_select,
  output logic             last
);

  logic [SEL_W-1:0] pos_r;
  logic [NUM_W-1:0] rem_r;
  logic [7:0]       shift_r;
  logic             ov_r;
  logic [7:0]       seg_r;
  logic [SEL_W-1:0] sel_r;
  logic             last_r;

  logic             emit;
  logic [NUM_W-1:0] rem_in;
  logic [NUM_W-1:0] weight;
  logic [NUM_W-1:0] thr [10];
  logic [3:0]       digit;
  logic [NUM_W-1:0] rem_nxt;
  logic             dot_on;
  logic [7:0]       seg_nxt;
  logic [SEL_W-1:0] sel_nxt;
  logic             last_nxt;

  // A result is formed whenever an item waits and the output register is free or draining.
  assign emit = head_valid && (!ov_r || out_ready);
  assign pop  = emit && last_nxt;

  // Peel one decimal digit per result by comparing against its multiples.
  assign rem_in = (pos_r == '0) ? head_item.num : rem_r;
  assign weight = place_weight(pos_r);

  always_comb begin
    thr[0] = '0;
    digit  = '0;
    for (int k = 1; k < 10; k++) begin
      thr[k] = NUM_W'(k) * weight;
      digit  = digit + 4'(rem_in >= thr[k]);
    end
  end

  assign rem_nxt = rem_in - thr[digit];
  assign dot_on  = (head_item.range != RANGE_OVERFLOW) &&
                   (head_item.range == range_t'(3'(pos_r)));

  // Segment byte, enable and end marker of the next result.
  always_comb begin
    if (head_item.func == FUNC_DIGIT) begin
      sel_nxt  = head_item.digit_pos;
      last_nxt = 1'b1;
      if (head_item.digit_code < 4'd10) begin
        seg_nxt = seg_pattern(head_item.digit_code) &
                  {!head_item.dot_en, 7'h7F};
      end else begin
        seg_nxt = shift_r;
      end
    end else begin
      sel_nxt  = pos_r;
      last_nxt = (pos_r == SEL_W'(DIGIT_COUNT - 1));
      seg_nxt  = seg_pattern(digit) & {!dot_on, 7'h7F};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      ov_r    <= 1'b0;
      shift_r <= SEG_BLANK;
    end else if (emit) begin
      ov_r    <= 1'b1;
      shift_r <= seg_nxt;
      pos_r   <= last_nxt ? '0 : pos_r + 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rem_r  <= rem_nxt;
      seg_r  <= seg_nxt;
      sel_r  <= sel_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid    = ov_r;
  assign segment_byte = seg_r;
  assign digit_select = sel_r;
  assign last         = last_r;

endmodule

[src/seven_segment_number_driver.sv]
`timescale 1ns / 1ps
// An accepted item passes front stage one, front stage two, the two-entry queue and the
// output register before out_tvalid rises and its first result can be taken.
// A number gives four results and a single digit one result; the digit sequencer forms
// one result per cycle into the output register while out_tready is high and an item waits.
// A new item is accepted every cycle while the two-entry queue has room.
// Reset (rst_n low, synchronous) empties pipeline and queue and blanks the shift byte.

module seven_segment_number_driver import ssnd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // value_milli[23:0], digit_code[27:24],
                                  // digit_pos[29:28], dot_en[30], zero[31]
  input  logic        in_tuser,   // func[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // segment_byte[7:0], digit_select[9:8], zero[15:10]
  output logic        out_tlast
);

  logic             push_valid;
  logic             push_ready;
  item_t            push_item;
  logic             head_valid;
  item_t            head_item;
  logic             pop;
  logic [7:0]       segment_byte;
  logic [SEL_W-1:0] digit_select;

  ssnd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_func     (in_tuser),
    .value_milli (in_tdata[23:0]),
    .digit_code  (in_tdata[27:24]),
    .digit_pos   (in_tdata[29:28]),
    .dot_en      (in_tdata[30]),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_item   (push_item)
  );

  ssnd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (head_valid),
    .pop        (pop),
    .pop_item   (head_item)
  );

  ssnd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (head_valid),
    .head_item    (head_item),
    .pop          (pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .segment_byte (segment_byte),
    .digit_select (digit_select),
    .last         (out_tlast)
  );

  assign out_tdata = {6'b0, digit_select, segment_byte};

endmodule

[tb/seven_segment_number_driver_tb.sv]
`timescale 1ns / 1ps

module seven_segment_number_driver_tb;
  import ssnd_pkg::*;

  localparam int RANDOM_ITEMS = 255;
  localparam int DRAIN_CYCLES = 16;

  // Active-low glyphs for digits 0 to 9, dot off.
  localparam logic [7:0] SEGMENT_CODES [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // value_milli[23:0], digit_code[27:24],
                           // digit_pos[29:28], dot_en[30], zero[31]
  logic        in_tuser;   // func[0]
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // segment_byte[7:0], digit_select[9:8], zero[15:10]
  logic        out_tlast;

  // When set, neither side inserts idle cycles.
  bit no_idle;

  // One displayed glyph as the block should emit it.
  typedef struct {
    logic [7:0] segments;
    logic [1:0] select;
    logic       last;
  } glyph_t;

  // Tracks the display shift register and the glyphs still owed by the block.
  class display_scoreboard;
    logic [7:0] shift_byte;
    glyph_t     expected_glyphs[$];
    int         mismatches;
    int         glyphs_checked;
    int         numbers_seen;
    int         digits_seen;
    int         invalid_seen;
    int         overflow_seen;
    int         carry_seen;

    function new();
      shift_byte = SEG_BLANK;
      mismatches = 0;
      glyphs_checked = 0;
      numbers_seen = 0;
      digits_seen = 0;
      invalid_seen = 0;
      overflow_seen = 0;
      carry_seen = 0;
    endfunction

    // A digit outside 0..9 shifts nothing, so the previous byte shows again.
    function logic [7:0] shift_in(int unsigned d, bit dot);
      if (d < 10) begin
        shift_byte = SEGMENT_CODES[d] & (dot ? 8'h7F : 8'hFF);
      end
      return shift_byte;
    endfunction

    // Work out the glyphs that one accepted item must produce.
    function void note_item(logic func, logic [31:0] word);
      glyph_t      g;
      int unsigned v;
      int unsigned n;
      int unsigned div;
      int unsigned dig;
      range_t      rng;
      if (func == FUNC_DIGIT) begin
        digits_seen++;
        if (word[27:24] > 4'd9) begin
          invalid_seen++;
        end
        g.segments = shift_in(word[27:24], word[30]);
        g.select = word[29:28];
        g.last = 1'b1;
        expected_glyphs.push_back(g);
      end else begin
        numbers_seen++;
        v = word[23:0];
        if (v >= LIMIT_OVERFLOW) begin
          rng = RANGE_OVERFLOW;
        end else if (v >= LIMIT_THOUSANDS) begin
          rng = RANGE_THOUSANDS;
        end else if (v >= LIMIT_HUNDREDS) begin
          rng = RANGE_HUNDREDS;
        end else if (v >= LIMIT_TENS) begin
          rng = RANGE_TENS;
        end else begin
          rng = RANGE_UNITS;
        end
        // Round half up; a carry to five digits moves to the next coarser range.
        n = 9999;
        while (rng != RANGE_OVERFLOW) begin
          case (rng)
            RANGE_THOUSANDS: n = (v + 500) / 1000;
            RANGE_HUNDREDS:  n = (v + 50) / 100;
            RANGE_TENS:      n = (v + 5) / 10;
            default:         n = v;
          endcase
          if (n < 10000) begin
            break;
          end
          carry_seen++;
          rng = range_t'(rng + 1);
        end
        if (rng == RANGE_OVERFLOW) begin
          overflow_seen++;
          n = 9999;
        end
        // Four digits, most significant first, dot after the integer part.
        div = 1000;
        for (int i = 0; i < DIGIT_COUNT; i++) begin
          dig = (n / div) % 10;
          g.segments = shift_in(dig, (rng != RANGE_OVERFLOW) && (i == int'(rng)));
          g.select = 2'(i);
          g.last = (i == DIGIT_COUNT - 1);
          expected_glyphs.push_back(g);
          div = div / 10;
        end
      end
    endfunction

    // Compare one emitted glyph with the oldest one owed.
    function void check_glyph(logic [7:0] seg, logic [1:0] sel, logic last);
      glyph_t e;
      if (expected_glyphs.size() == 0) begin
        $error("unexpected result: segment_byte %h digit_select %0d last %0b",
               seg, sel, last);
        mismatches++;
        return;
      end
      e = expected_glyphs.pop_front();
      glyphs_checked++;
      if (seg !== e.segments) begin
        $error("segment_byte: expected %h, actual %h", e.segments, seg);
        mismatches++;
      end
      if (sel !== e.select) begin
        $error("digit_select: expected %0d, actual %0d", e.select, sel);
        mismatches++;
      end
      if (last !== e.last) begin
        $error("last: expected %0b, actual %0b", e.last, last);
        mismatches++;
      end
    endfunction
  endclass

  display_scoreboard sb = new();

  seven_segment_number_driver DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 30);
  endfunction

  // Number item; the digit fields carry random junk that must be ignored.
  function automatic logic [31:0] number_word(logic [23:0] v);
    logic [6:0] junk;
    junk = 7'($urandom_range(0, 127));
    return {1'b0, junk, v};
  endfunction

  // Digit item; the number field carries random junk that must be ignored.
  function automatic logic [31:0] digit_word(logic [3:0] dv, logic [1:0] idx, logic dot);
    logic [23:0] junk;
    junk = 24'($urandom());
    return {1'b0, dot, idx, dv, junk};
  endfunction

  // Offer one item after a random gap and hold it until it is taken.
  task automatic send_item(input logic func, input logic [31:0] word);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
  endtask

  // Random number value, weighted toward every range and its rounding edges.
  function automatic logic [23:0] random_value();
    int unsigned scale;
    int unsigned m;
    case ($urandom_range(0, 9))
      0, 1: return 24'($urandom());
      2: return 24'($urandom_range(0, 9999));
      3: return 24'($urandom_range(10000, 99999));
      4: return 24'($urandom_range(100000, 999999));
      5: return 24'($urandom_range(1000000, 9999999));
      6: return 24'($urandom_range(10000000, 24'hFFFFFF));
      default: begin
        // Just below or exactly at half of the dropped place.
        m = $urandom_range(0, 2);
        scale = (m == 0) ? 10 : ((m == 1) ? 100 : 1000);
        m = ($urandom_range(0, 3) == 0) ? 9999 : $urandom_range(1000, 9999);
        return 24'(m * scale + scale / 2 - $urandom_range(0, 1));
      end
    endcase
  endfunction

  // Result side: ready runs broken by random stalls.
  initial begin
    int run;
    int stall;
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      run = $urandom_range(1, 12);
      out_tready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Record accepted items and check accepted results.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      sb.note_item(in_tuser, in_tdata);
    end
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_glyph(out_tdata[7:0], out_tdata[9:8], out_tlast);
    end
  end

  // Stimulus.
  initial begin
    logic [23:0] v;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = FUNC_NUMBER;
    no_idle   = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Invalid digit straight after reset shows the blank byte.
    send_item(FUNC_DIGIT, digit_word(4'd12, 2'd0, 1'b1));
    send_item(FUNC_DIGIT, digit_word(4'd0, 2'd0, 1'b0));
    send_item(FUNC_DIGIT, digit_word(4'd9, 2'd3, 1'b1));
    send_item(FUNC_DIGIT, digit_word(4'd15, 2'd2, 1'b0));
    send_item(FUNC_DIGIT, digit_word(4'd10, 2'd1, 1'b1));
    send_item(FUNC_DIGIT, digit_word(4'd8, 2'd1, 1'b1));

    // Range edges, rounding carries and overflow.
    send_item(FUNC_NUMBER, number_word(24'd0));
    send_item(FUNC_NUMBER, number_word(24'd1));
    send_item(FUNC_NUMBER, number_word(24'd9999));
    send_item(FUNC_NUMBER, number_word(24'd10000));
    send_item(FUNC_NUMBER, number_word(24'd99994));
    send_item(FUNC_NUMBER, number_word(24'd99995));
    send_item(FUNC_NUMBER, number_word(24'd100000));
    send_item(FUNC_NUMBER, number_word(24'd999949));
    send_item(FUNC_NUMBER, number_word(24'd999950));
    send_item(FUNC_NUMBER, number_word(24'd1000000));
    send_item(FUNC_NUMBER, number_word(24'd9999499));
    send_item(FUNC_NUMBER, number_word(24'd9999500));
    send_item(FUNC_NUMBER, number_word(24'd9999999));
    send_item(FUNC_NUMBER, number_word(24'd10000000));
    send_item(FUNC_NUMBER, number_word(24'hFFFFFF));
    send_item(FUNC_NUMBER, number_word(24'd1234567));
    send_item(FUNC_NUMBER, number_word(24'd54321));

    // Invalid digit after a number repeats its last glyph.
    send_item(FUNC_DIGIT, digit_word(4'd11, 2'd3, 1'b1));
    send_item(FUNC_DIGIT, digit_word(4'd7, 2'd2, 1'b1));

    // Random items, with one stretch where neither side idles.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      no_idle = (i >= 120 && i < 170);
      if ($urandom_range(0, 9) < 6) begin
        v = random_value();
        send_item(FUNC_NUMBER, number_word(v));
      end else begin
        send_item(FUNC_DIGIT, digit_word(4'($urandom_range(0, 15)),
                                         2'($urandom_range(0, 3)),
                                         1'($urandom_range(0, 1))));
      end
    end
    no_idle = 1'b0;
    in_tvalid <= 1'b0;

    // Drain, then give the block time to show any stray result.
    while (sb.expected_glyphs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.expected_glyphs.size() != 0) begin
      $error("%0d expected results never arrived", sb.expected_glyphs.size());
      sb.mismatches++;
    end

    $display("Covered %0d number items (%0d shown as overflow, %0d rounding carries)",
             sb.numbers_seen, sb.overflow_seen, sb.carry_seen);
    $display("and %0d digit items (%0d invalid); %0d results checked.",
             sb.digits_seen, sb.invalid_seen, sb.glyphs_checked);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
